@@ src/graph_segment_union_find_macros.svh @@
// Assertion helpers for the one file that checks itself.
`ifndef GRAPH_SEGMENT_UNION_FIND_MACROS_SVH
`define GRAPH_SEGMENT_UNION_FIND_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GSUF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GSUF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/gsuf_pkg.sv @@
package gsuf_pkg;

	localparam int MAX_VERTICES     = 4096;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int WW               = WEIGHT_FRAC_BITS + 2;
	localparam int RANK_W           = 4;

	localparam logic [WW-1:0]     K_RESET     = WW'(655);
	localparam logic [12:0]       MIN_RESET   = 13'd20;
	localparam logic [12:0]       COUNT_RESET = 13'd4096;
	localparam logic [RANK_W-1:0] RANK_MAX    = '1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_THRESH = 2'd1,
		OP_SMALL = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MERGE_K = 2'd0,
		REG_MIN_SIZE = 2'd1,
		REG_VCOUNT = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

endpackage

@@ src/gsuf_div.sv @@
module gsuf_div #(
	parameter int CW = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [gsuf_pkg::WW-1:0] dividend,
	input  logic [CW-1:0]          divisor,
	output logic                   done,
	output logic [gsuf_pkg::WW-1:0] quotient
);
	import gsuf_pkg::*;

	localparam int NW = $clog2(WW + 1);

	logic [WW-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic [NW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [CW:0]   trial;
	logic          fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[WW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && cnt_q == NW'(1);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NW'(WW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[WW-2:0], fits};
			rem_q <= fits ? CW'(trial - {1'b0, divisor}) : CW'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/graph_segment_union_find.sv @@
// Union-find engine for threshold graph segmentation. All forest state sits in one
// synchronous node memory (parent, rank, size, threshold per vertex) with a registered
// read; the engine walks parent chains one hop per cycle and writes back. After reset
// and after every clear operation the memory is swept, one vertex a cycle, so no word
// is taken until the sweep ends (configuration writes are still taken). A threshold
// merge that joins also runs a serial divide of the merge constant by the new set
// size; a busy output stalls the result.
`include "graph_segment_union_find_macros.svh"

module graph_segment_union_find (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // vertex_a[11:0], vertex_b[23:12], weight[41:24], zero fill
	input  logic [1:0]  s_tuser,   // operation[1:0]
	input  logic        s_tlast,   // last_edge
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // label[11:0], merged[12], segment_size[25:13],
	                               // segment_count[38:26], zero fill
	output logic        m_tlast,   // pass_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import gsuf_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	typedef struct packed {
		logic [VW-1:0]     parent;
		logic [RANK_W-1:0] rank;
		logic [CW-1:0]     size;
		logic [WW-1:0]     thr;
	} node_t;

	typedef enum logic [10:0] {
		S_INIT  = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_CLEAR = 11'b000_0000_0100,
		S_RD    = 11'b000_0000_1000,
		S_CHK   = 11'b000_0001_0000,
		S_DEC   = 11'b000_0010_0000,
		S_JOIN  = 11'b000_0100_0000,
		S_DIV   = 11'b000_1000_0000,
		S_ROOTW = 11'b001_0000_0000,
		S_VAW   = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		PH_A = 3'b001,
		PH_B = 3'b010,
		PH_L = 3'b100
	} phase_t;

	function automatic logic [CW-1:0] clamp_count(input logic [12:0] n);
		if (n == 13'd0) return CW'(1);
		if (n > 13'(MAX_VERTICES)) return CW'(MAX_VERTICES);
		return CW'(n);
	endfunction

	node_t mem [MAX_VERTICES];
	node_t rd_node;
	logic [VW-1:0] rd_addr;
	logic          wr_en;
	logic [VW-1:0] wr_addr;
	node_t         wr_data;

	state_t state_q;
	phase_t phase_q;

	logic [WW-1:0] k_q;
	logic [12:0]   min_q;
	logic [12:0]   vcount_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] set_count_q;
	logic [WW-1:0] thr_fill_q;
	logic [VW-1:0] ptr_q;

	op_t           op_q;
	logic [11:0]   va_q;
	logic [VW-1:0] vb_q;
	logic [WW-1:0] w_q;
	logic          pass_q;

	logic [VW-1:0] cur_q;
	logic          first_q;
	node_t         start_node_q;
	logic [VW-1:0] ra_q, rb_q, r_q, c_q;
	node_t         wa_q, wb_q, va_node_q, rnode_q, cnode_q;

	logic [11:0]   res_label_q;
	logic [CW-1:0] res_seg_q;
	logic          res_merged_q;

	logic          m_tvalid_q;
	logic [39:0]   m_tdata_q;
	logic          m_tlast_q;

	logic [11:0]   in_va, in_vb;
	op_t           in_op;
	logic          a_ok, b_ok;
	logic          is_root;
	node_t         start_word;
	logic          join_ok;
	logic          a_big;
	logic [CW-1:0] sum_size;
	logic [RANK_W-1:0] new_rank;
	node_t         cnode_d, rnode_d;
	logic          div_start, div_done;
	logic [WW-1:0] div_q;
	logic [WW:0]   thr_sum;

	assign in_op = op_t'(s_tuser);
	assign in_va = s_tdata[11:0];
	assign in_vb = s_tdata[23:12];
	assign a_ok  = {1'b0, in_va} < 13'(active_q);
	assign b_ok  = {1'b0, in_vb} < 13'(active_q);

	assign is_root    = rd_node.parent == cur_q;
	assign start_word = first_q ? rd_node : start_node_q;

	assign sum_size = wa_q.size + wb_q.size;
	assign a_big    = wa_q.rank > wb_q.rank;
	assign new_rank = (!a_big && wa_q.rank == wb_q.rank && wb_q.rank != RANK_MAX)
		? wb_q.rank + 1'b1 : wb_q.rank;

	// child and new root words of a join
	always_comb begin
		cnode_d        = a_big ? wb_q : wa_q;
		cnode_d.parent = a_big ? ra_q : rb_q;
		rnode_d        = a_big ? wa_q : wb_q;
		rnode_d.size   = sum_size;
		rnode_d.rank   = a_big ? wa_q.rank : new_rank;
	end

	always_comb begin
		join_ok = 1'b0;
		if (ra_q != rb_q) begin
			if (op_q == OP_THRESH) begin
				join_ok = (w_q <= wa_q.thr) && (w_q <= wb_q.thr);
			end else begin
				join_ok = (13'(wa_q.size) < min_q) || (13'(wb_q.size) < min_q);
			end
		end
	end

	assign thr_sum   = {1'b0, w_q} + {1'b0, div_q};
	assign div_start = state_q == S_JOIN && op_q == OP_THRESH;

	gsuf_div #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (k_q),
		.divisor  (rnode_q.size),
		.done     (div_done),
		.quotient (div_q)
	);

	// read address and the single write port
	always_comb begin
		rd_addr = cur_q;
		if (state_q == S_CHK && !is_root) rd_addr = rd_node.parent;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = '{parent: ptr_q, rank: '0, size: CW'(1), thr: thr_fill_q};
		case (state_q)
			S_INIT, S_CLEAR: wr_en = 1'b1;
			S_CHK: begin
				// re-point the starting vertex at its root
				if (is_root && !first_q) begin
					wr_en          = 1'b1;
					wr_addr        = (phase_q == PH_B) ? vb_q : va_q[VW-1:0];
					wr_data        = start_node_q;
					wr_data.parent = cur_q;
				end
			end
			S_JOIN: begin
				wr_en   = 1'b1;
				wr_addr = c_q;
				wr_data = cnode_q;
			end
			S_ROOTW: begin
				wr_en   = 1'b1;
				wr_addr = r_q;
				wr_data = rnode_q;
			end
			S_VAW: begin
				wr_en          = 1'b1;
				wr_addr        = va_q[VW-1:0];
				wr_data        = va_node_q;
				wr_data.parent = r_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_node <= mem[rd_addr];
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= K_RESET;
			min_q    <= MIN_RESET;
			vcount_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MERGE_K:  k_q      <= cfg_data;
				REG_MIN_SIZE: min_q    <= cfg_data[12:0];
				REG_VCOUNT:   vcount_q <= cfg_data[12:0];
				default:      k_q      <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			phase_q     <= PH_L;
			ptr_q       <= '0;
			thr_fill_q  <= K_RESET;
			active_q    <= clamp_count(COUNT_RESET);
			set_count_q <= clamp_count(COUNT_RESET);
			first_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) m_tvalid_q <= 1'b0;
			case (state_q)
				S_INIT, S_CLEAR: begin
					if (ptr_q == VW'(MAX_VERTICES - 1)) begin
						ptr_q   <= '0;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_OUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						if (in_op == OP_CLEAR) begin
							active_q    <= clamp_count(vcount_q);
							set_count_q <= clamp_count(vcount_q);
							thr_fill_q  <= k_q;
							ptr_q       <= '0;
							state_q     <= S_CLEAR;
						end else if (a_ok) begin
							cur_q   <= in_va[VW-1:0];
							first_q <= 1'b1;
							phase_q <= (b_ok && in_op != OP_QUERY) ? PH_A : PH_L;
							state_q <= S_RD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					first_q <= is_root && phase_q == PH_A;
					if (first_q) start_node_q <= rd_node;
					if (!is_root) begin
						cur_q <= rd_node.parent;
					end else begin
						case (phase_q)
							PH_A: begin
								ra_q      <= cur_q;
								wa_q      <= rd_node;
								va_node_q <= start_word;
								cur_q     <= vb_q;
								phase_q   <= PH_B;
								state_q   <= S_RD;
							end
							PH_B: begin
								rb_q    <= cur_q;
								wb_q    <= rd_node;
								state_q <= S_DEC;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_DEC: begin
					if (join_ok) begin
						set_count_q <= set_count_q - 1'b1;
						state_q     <= S_JOIN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_JOIN: state_q <= (op_q == OP_THRESH) ? S_DIV : S_ROOTW;
				S_DIV: if (div_done) state_q <= S_ROOTW;
				S_ROOTW: state_q <= (va_q[VW-1:0] != r_q) ? S_VAW : S_OUT;
				S_VAW: state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q         <= in_op;
				va_q         <= in_va;
				vb_q         <= in_vb[VW-1:0];
				w_q          <= s_tdata[41:24];
				pass_q       <= (in_op == OP_THRESH || in_op == OP_SMALL) && s_tlast;
				res_merged_q <= 1'b0;
				res_label_q  <= (in_op == OP_CLEAR) ? 12'd0 : in_va;
				res_seg_q    <= '0;
			end
			S_CHK: begin
				if (is_root && phase_q == PH_L) begin
					res_label_q <= 12'(cur_q);
					res_seg_q   <= rd_node.size;
				end
			end
			S_DEC: begin
				res_label_q <= 12'(ra_q);
				res_seg_q   <= wa_q.size;
				r_q         <= a_big ? ra_q : rb_q;
				c_q         <= a_big ? rb_q : ra_q;
				cnode_q     <= cnode_d;
				rnode_q     <= rnode_d;
			end
			S_DIV: begin
				if (div_done) rnode_q.thr <= thr_sum[WW] ? '1 : thr_sum[WW-1:0];
			end
			S_ROOTW: begin
				res_label_q  <= 12'(r_q);
				res_seg_q    <= rnode_q.size;
				res_merged_q <= 1'b1;
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {1'b0, 13'(set_count_q), 13'(res_seg_q), res_merged_q,
						res_label_q};
					m_tlast_q <= pass_q && (op_q != OP_CLEAR);
				end
			end
			default: m_tlast_q <= m_tlast_q;
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`GSUF_ASSERT_NOW(a_count_bound, 1'b1, set_count_q <= active_q, "set count above active count")
	`GSUF_ASSERT_NXT(a_join_dec, state_q == S_DEC && join_ok,
		set_count_q == $past(set_count_q) - 1'b1, "join did not drop the set count")
	`GSUF_ASSERT_NOW(a_sweep_block, state_q == S_INIT || state_q == S_CLEAR, !s_tready,
		"word taken during memory sweep")

endmodule
